### hw/rtl/smf_pkg.sv
// Shared types, request codes and acceptance-curve tables for the spin-flip engine.
`timescale 1ns / 1ps
`default_nettype none
package smf_pkg;

	// request codes
	typedef enum logic [2:0] {
		REQ_LIT    = 3'd0,
		REQ_LEN    = 3'd1,
		REQ_ADJ    = 3'd2,
		REQ_ADJCNT = 3'd3,
		REQ_SPIN   = 3'd4,
		REQ_ENERGY = 3'd5,
		REQ_FLIP   = 3'd6,
		REQ_NONE   = 3'd7
	} req_t;

	localparam int ENERGY_MAX = 8191;
	localparam int X_MAX      = 4095;

	// clause evaluator status
	typedef struct packed {
		logic done;
		logic unsat;
	} eval_stat_t;

	// acceptance unit status
	typedef struct packed {
		logic done;
		logic accepted;
	} acc_stat_t;

	typedef logic [63:0] q62_t;
	typedef q62_t frac_tab_t [256];
	typedef q62_t whole_tab_t [16];

	localparam q62_t Q_ONE = 64'h4000_0000_0000_0000;

	// Q62 product of two values not above one
	function automatic q62_t qmul(q62_t a, q62_t b);
		q62_t a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
		a0  = {32'd0, a[31:0]};
		a1  = {32'd0, a[63:32]};
		b0  = {32'd0, b[31:0]};
		b1  = {32'd0, b[63:32]};
		p00 = a0 * b0;
		p01 = a0 * b1;
		p10 = a1 * b0;
		p11 = a1 * b1;
		mid = (p00 >> 32) + {32'd0, p01[31:0]} + {32'd0, p10[31:0]};
		lo  = {mid[31:0], p00[31:0]};
		hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
		return (hi << 2) | (lo >> 62);
	endfunction

	// restoring long division of a Q62 term by a small series index
	function automatic q62_t qdiv_small(q62_t num, q62_t den);
		q62_t quo, rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-t) in Q62 by a 32-term series, t in [0,1]
	function automatic q62_t qexp_neg(q62_t t);
		q62_t sum, term, k;
		sum  = Q_ONE;
		term = Q_ONE;
		for (k = 64'd1; k <= 64'd32; k = k + 64'd1) begin
			term = qdiv_small(qmul(term, t), k);
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic frac_tab_t build_frac();
		frac_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = qexp_neg(q62_t'(i) << 54);
		end
		return tab;
	endfunction

	function automatic whole_tab_t build_whole();
		whole_tab_t tab;
		q62_t e1;
		e1 = qexp_neg(Q_ONE);
		tab[0] = Q_ONE;
		for (int i = 1; i < 16; i++) begin
			tab[i] = qmul(tab[i-1], e1);
		end
		return tab;
	endfunction

	// exp(-f/256) and exp(-w)
	localparam frac_tab_t  FRAC_TAB  = build_frac();
	localparam whole_tab_t WHOLE_TAB = build_whole();

endpackage
`default_nettype wire

### hw/rtl/sat_metropolis_flip.sv
// Top level: formula and spin memories, request sequencer, config port.
// Table writes, set spin and unused codes pass through a read-spin state and a finish state.
// Recompute evaluates each counted clause in turn; flip evaluates the variable's clauses
// before and after the toggle, then may run the acceptance unit. Both are paced by the
// one-literal-per-cycle walk through the literal and spin memories.
// One request at a time; done pulses once per request and cannot be stalled.
// Reset clears control, the clause-count register and energy only; memory contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sat_metropolis_flip #(
	parameter int NUM_VARS    = 1024,
	parameter int NUM_CLAUSES = 4096,
	parameter int MAX_LITS    = 8,
	parameter int MAX_CONN    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [9:0]  var_index,
	input  wire logic [11:0] clause_index,
	input  wire logic [4:0]  slot,
	input  wire logic        negated,
	input  wire logic [5:0]  count,
	input  wire logic        spin_value,
	input  wire logic [15:0] inv_temp,
	input  wire logic [15:0] random,
	output logic             done,
	output logic             accepted,
	output logic [6:0]       delta,
	output logic [12:0]      energy,
	output logic             spin_now,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int VW  = $clog2(NUM_VARS);
	localparam int CW  = (NUM_CLAUSES > 1) ? $clog2(NUM_CLAUSES) : 1;
	localparam int CCW = $clog2(NUM_CLAUSES + 1);
	localparam int LW  = $clog2(MAX_LITS + 1);
	localparam int NW  = $clog2(MAX_CONN + 1);
	localparam int DW  = NW + 1;
	localparam int LAW = $clog2(NUM_CLAUSES * MAX_LITS);
	localparam int AAW = $clog2(NUM_VARS * MAX_CONN);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_CNT    = 12'b000000000010,
		S_ADJ    = 12'b000000000100,
		S_ADJW   = 12'b000000001000,
		S_EVAL   = 12'b000000010000,
		S_TOG    = 12'b000000100000,
		S_ACC    = 12'b000001000000,
		S_COMMIT = 12'b000010000000,
		S_REC    = 12'b000100000000,
		S_RECW   = 12'b001000000000,
		S_RDSP   = 12'b010000000000,
		S_FIN    = 12'b100000000000
	} st_t;

	st_t                 state_q;
	logic [12:0]         clauses_q;
	logic [12:0]         energy_q;
	logic [VW-1:0]       var_q;
	logic                var_ok_q;
	logic [15:0]         itemp_q;
	logic [15:0]         rnd_q;
	logic [NW-1:0]       n_q, k_q, total_q, before_q;
	logic                pass_q;
	logic                old_q;
	logic                acc_q;
	logic signed [DW-1:0] dfull_q;
	logic [CCW-1:0]      c_q, e_q;

	logic                take;
	logic [31:0]         var32, cl32, slot32, cnt32, lim32;
	logic [31:0]         lit_a32, adj_a32, adj_r32, cl_a32;
	logic                var_ok, cl_ok;
	logic [VW-1:0]       var_idx;
	logic [CW-1:0]       cl_idx;
	logic signed [DW-1:0] dnext;
	logic signed [31:0]  d32, e32;
	logic [CCW-1:0]      lim;

	// memory ports
	logic                lit_we, len_we, adj_we, cnt_we, spin_we;
	logic [LAW-1:0]      lit_waddr, lit_raddr;
	logic [VW:0]         lit_rdata;
	logic [CW-1:0]       len_raddr;
	logic [LW-1:0]       len_wdata, len_rdata;
	logic [AAW-1:0]      adj_waddr, adj_raddr;
	logic [CW-1:0]       adj_rdata;
	logic [VW-1:0]       cnt_raddr;
	logic [NW-1:0]       cnt_wdata, cnt_rdata;
	logic [VW-1:0]       spin_waddr, spin_raddr, ev_spin_raddr;
	logic                spin_wdata, spin_rdata;

	logic                ev_start;
	logic [CW-1:0]       ev_clause;
	smf_pkg::eval_stat_t ev_stat;
	logic                acc_start;
	smf_pkg::acc_stat_t  acc_stat;

	// request decode
	always_comb begin
		take    = start && (state_q == S_IDLE);
		busy    = (state_q != S_IDLE);
		var32   = 32'(var_index);
		cl32    = 32'(clause_index);
		slot32  = 32'(slot);
		cnt32   = 32'(count);
		var_ok  = var32 < NUM_VARS;
		cl_ok   = cl32 < NUM_CLAUSES;
		var_idx = var32[VW-1:0];
		cl_idx  = cl32[CW-1:0];
		lit_a32 = cl32 * MAX_LITS + slot32;
		adj_a32 = var32 * MAX_CONN + slot32;
		adj_r32 = 32'(var_q) * MAX_CONN + 32'(k_q);
		lim32   = (32'(clauses_q) < NUM_CLAUSES) ? 32'(clauses_q) : NUM_CLAUSES;
		lim     = lim32[CCW-1:0];
		cl_a32  = 32'(c_q);
		dnext   = $signed({1'b0, total_q}) - $signed({1'b0, before_q});
		d32     = 32'(dfull_q);
		e32     = $signed({19'd0, energy_q}) + d32;
	end

	// table writes
	always_comb begin
		lit_we    = take && (req_type == smf_pkg::REQ_LIT) && var_ok && cl_ok
			&& (slot32 < MAX_LITS);
		lit_waddr = lit_a32[LAW-1:0];
		len_we    = take && (req_type == smf_pkg::REQ_LEN) && cl_ok;
		len_wdata = (cnt32 > MAX_LITS) ? LW'(MAX_LITS) : cnt32[LW-1:0];
		adj_we    = take && (req_type == smf_pkg::REQ_ADJ) && var_ok && cl_ok
			&& (slot32 < MAX_CONN);
		adj_waddr = adj_a32[AAW-1:0];
		adj_raddr = adj_r32[AAW-1:0];
		cnt_we    = take && (req_type == smf_pkg::REQ_ADJCNT) && var_ok;
		cnt_wdata = (cnt32 > MAX_CONN) ? NW'(MAX_CONN) : cnt32[NW-1:0];
		cnt_raddr = var_idx;
	end

	// spin port: set spin, flip toggle, restore on rejection
	always_comb begin
		spin_we    = 1'b0;
		spin_waddr = var_q;
		spin_wdata = ~spin_rdata;
		if (take && (req_type == smf_pkg::REQ_SPIN) && var_ok) begin
			spin_we    = 1'b1;
			spin_waddr = var_idx;
			spin_wdata = spin_value;
		end else if (state_q == S_TOG) begin
			spin_we = 1'b1;
		end else if (state_q == S_COMMIT && !acc_q) begin
			spin_we    = 1'b1;
			spin_wdata = old_q;
		end
		spin_raddr = (state_q == S_EVAL || state_q == S_RECW) ? ev_spin_raddr : var_q;
	end

	// clause evaluator and acceptance unit launch
	always_comb begin
		ev_start  = (state_q == S_ADJW) || (state_q == S_REC && c_q != lim);
		ev_clause = (state_q == S_REC) ? cl_a32[CW-1:0] : adj_rdata;
		acc_start = (state_q == S_ADJ) && (k_q == n_q) && pass_q && (dnext > 0);
	end

	smf_ram #(.WIDTH(VW + 1), .DEPTH(NUM_CLAUSES * MAX_LITS)) u_lit_ram (
		.clk(clk), .we(lit_we), .waddr(lit_waddr),
		.wdata({negated, var_idx}), .raddr(lit_raddr), .rdata(lit_rdata)
	);

	smf_ram #(.WIDTH(LW), .DEPTH(NUM_CLAUSES)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(cl_idx),
		.wdata(len_wdata), .raddr(len_raddr), .rdata(len_rdata)
	);

	smf_ram #(.WIDTH(CW), .DEPTH(NUM_VARS * MAX_CONN)) u_adj_ram (
		.clk(clk), .we(adj_we), .waddr(adj_waddr),
		.wdata(cl_idx), .raddr(adj_raddr), .rdata(adj_rdata)
	);

	smf_ram #(.WIDTH(NW), .DEPTH(NUM_VARS)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(var_idx),
		.wdata(cnt_wdata), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	smf_ram #(.WIDTH(1), .DEPTH(NUM_VARS)) u_spin_ram (
		.clk(clk), .we(spin_we), .waddr(spin_waddr),
		.wdata(spin_wdata), .raddr(spin_raddr), .rdata(spin_rdata)
	);

	smf_clause_eval #(
		.NUM_VARS(NUM_VARS), .NUM_CLAUSES(NUM_CLAUSES), .MAX_LITS(MAX_LITS)
	) u_eval (
		.clk(clk), .arst_n(arst_n), .start(ev_start), .clause(ev_clause),
		.len_raddr(len_raddr), .len_rdata(len_rdata),
		.lit_raddr(lit_raddr), .lit_rdata(lit_rdata),
		.spin_raddr(ev_spin_raddr), .spin_rdata(spin_rdata), .stat(ev_stat)
	);

	smf_accept #(.DMW(NW)) u_accept (
		.clk(clk), .arst_n(arst_n), .start(acc_start), .dmag(dnext[NW-1:0]),
		.inv_temp(itemp_q), .random(rnd_q), .stat(acc_stat)
	);

	// config port and energy output
	always_comb begin
		pready = 1'b1;
		prdata = paddr[2] ? 32'd0 : {19'd0, clauses_q};
		energy = energy_q;
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clauses_q <= '0;
			energy_q  <= '0;
			done      <= 1'b0;
			pass_q    <= 1'b0;
			k_q       <= '0;
			n_q       <= '0;
			total_q   <= '0;
			c_q       <= '0;
			e_q       <= '0;
		end else begin
			done <= 1'b0;
			if (psel && penable && pwrite && !paddr[2]) begin
				clauses_q <= pwdata[12:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req_type == smf_pkg::REQ_FLIP && var_ok) begin
							state_q <= S_CNT;
						end else if (req_type == smf_pkg::REQ_ENERGY) begin
							c_q     <= '0;
							e_q     <= '0;
							state_q <= S_REC;
						end else begin
							state_q <= S_RDSP;
						end
					end
				end
				S_CNT: begin
					n_q     <= cnt_rdata;
					k_q     <= '0;
					total_q <= '0;
					pass_q  <= 1'b0;
					state_q <= S_ADJ;
				end
				S_ADJ: begin
					if (k_q != n_q) begin
						state_q <= S_ADJW;
					end else if (!pass_q) begin
						state_q <= S_TOG;
					end else if (dnext > 0) begin
						state_q <= S_ACC;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_ADJW: state_q <= S_EVAL;
				S_EVAL: begin
					if (ev_stat.done) begin
						total_q <= total_q + NW'(ev_stat.unsat);
						k_q     <= k_q + 1'b1;
						state_q <= S_ADJ;
					end
				end
				S_TOG: begin
					total_q <= '0;
					k_q     <= '0;
					pass_q  <= 1'b1;
					state_q <= S_ADJ;
				end
				S_ACC: begin
					if (acc_stat.done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (acc_q) begin
						if (e32 < 0) begin
							energy_q <= '0;
						end else if (e32 > smf_pkg::ENERGY_MAX) begin
							energy_q <= 13'(smf_pkg::ENERGY_MAX);
						end else begin
							energy_q <= e32[12:0];
						end
					end
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REC: begin
					if (c_q == lim) begin
						energy_q <= (32'(e_q) > smf_pkg::ENERGY_MAX)
							? 13'(smf_pkg::ENERGY_MAX) : 13'(e_q);
						state_q  <= S_RDSP;
					end else begin
						state_q <= S_RECW;
					end
				end
				S_RECW: begin
					if (ev_stat.done) begin
						e_q     <= e_q + CCW'(ev_stat.unsat);
						c_q     <= c_q + 1'b1;
						state_q <= S_REC;
					end
				end
				S_RDSP: state_q <= S_FIN;
				S_FIN: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload and result registers
	always_ff @(posedge clk) begin
		if (take) begin
			var_q    <= var_idx;
			var_ok_q <= var_ok;
			itemp_q  <= inv_temp;
			rnd_q    <= random;
		end
		if (state_q == S_TOG) begin
			old_q    <= spin_rdata;
			before_q <= total_q;
		end
		if (state_q == S_ADJ && k_q == n_q && pass_q) begin
			dfull_q <= dnext;
			acc_q   <= 1'b1;
		end
		if (state_q == S_ACC && acc_stat.done) begin
			acc_q <= acc_stat.accepted;
		end
		if (state_q == S_COMMIT) begin
			accepted <= acc_q;
			spin_now <= acc_q ? ~old_q : old_q;
			if (d32 > 63) begin
				delta <= 7'd63;
			end else if (d32 < -64) begin
				delta <= 7'h40;
			end else begin
				delta <= d32[6:0];
			end
		end
		if (state_q == S_FIN) begin
			accepted <= 1'b0;
			delta    <= '0;
			spin_now <= var_ok_q & spin_rdata;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/smf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module smf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/smf_clause_eval.sv
// Clause evaluator: walks one clause's literals through the literal and spin memories.
`timescale 1ns / 1ps
`default_nettype none
module smf_clause_eval #(
	parameter int NUM_VARS    = 1024,
	parameter int NUM_CLAUSES = 4096,
	parameter int MAX_LITS    = 8,
	localparam int VW  = $clog2(NUM_VARS),
	localparam int CW  = (NUM_CLAUSES > 1) ? $clog2(NUM_CLAUSES) : 1,
	localparam int LW  = $clog2(MAX_LITS + 1),
	localparam int LAW = $clog2(NUM_CLAUSES * MAX_LITS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CW-1:0]     clause,
	output logic      [CW-1:0]     len_raddr,
	input  wire logic [LW-1:0]     len_rdata,
	output logic      [LAW-1:0]    lit_raddr,
	input  wire logic [VW:0]       lit_rdata,
	output logic      [VW-1:0]     spin_raddr,
	input  wire logic              spin_rdata,
	output smf_pkg::eval_stat_t    stat
);

	typedef enum logic [2:0] {
		E_IDLE = 3'b001,
		E_LEN  = 3'b010,
		E_RUN  = 3'b100
	} est_t;

	est_t           state_q;
	logic [CW-1:0]  clause_q;
	logic [LAW-1:0] base_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  m_q;
	logic           sat_q;
	logic           lit_v_s1;
	logic           spin_v_s2;
	logic           neg_s2;
	logic           issue;
	logic           fin;
	logic [31:0]    base32;

	// addresses: length on start, literal per issue, spin from literal data
	always_comb begin
		base32     = 32'(clause_q) * MAX_LITS;
		len_raddr  = clause;
		lit_raddr  = base_q + LAW'(m_q);
		spin_raddr = lit_rdata[VW-1:0];
		issue      = (state_q == E_RUN) && (m_q != len_q);
		fin        = (state_q == E_RUN) && !issue && !lit_v_s1 && !spin_v_s2;
		stat.done  = fin;
		stat.unsat = ~sat_q;
	end

	// sequencer and literal pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_IDLE;
			lit_v_s1  <= 1'b0;
			spin_v_s2 <= 1'b0;
			sat_q     <= 1'b0;
			m_q       <= '0;
			len_q     <= '0;
		end else begin
			lit_v_s1  <= issue;
			spin_v_s2 <= lit_v_s1;
			if (spin_v_s2 && (spin_rdata != neg_s2)) begin
				sat_q <= 1'b1;
			end
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						state_q <= E_LEN;
					end
				end
				E_LEN: begin
					len_q   <= len_rdata;
					m_q     <= '0;
					sat_q   <= 1'b0;
					state_q <= E_RUN;
				end
				E_RUN: begin
					if (issue) begin
						m_q <= m_q + 1'b1;
					end
					if (fin) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start) begin
			clause_q <= clause;
		end
		if (state_q == E_LEN) begin
			base_q <= base32[LAW-1:0];
		end
		neg_s2 <= lit_rdata[VW];
	end

endmodule
`default_nettype wire

### hw/rtl/smf_accept.sv
// Metropolis acceptance unit: scaled delta, exp lookup, serial Q62 product, compare.
`timescale 1ns / 1ps
`default_nettype none
module smf_accept #(
	parameter int DMW = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DMW-1:0] dmag,
	input  wire logic [15:0]    inv_temp,
	input  wire logic [15:0]    random,
	output smf_pkg::acc_stat_t  stat
);

	typedef enum logic [8:0] {
		P_IDLE  = 9'b000000001,
		P_CLAMP = 9'b000000010,
		P_TAB   = 9'b000000100,
		P_M0    = 9'b000001000,
		P_M1    = 9'b000010000,
		P_M2    = 9'b000100000,
		P_M3    = 9'b001000000,
		P_MID   = 9'b010000000,
		P_FIN   = 9'b100000000
	} pst_t;

	pst_t                  phase_q;
	logic [DMW+15:0]       prod_q;
	logic [11:0]           x_q;
	logic                  xz_q;
	logic [15:0]           rnd_q;
	smf_pkg::q62_t         a_q, b_q, p00_q, p01_q, p10_q, p11_q;
	logic [33:0]           mid_q;
	logic [31:0]           op_a, op_b;
	logic [63:0]           mul;
	smf_pkg::q62_t         hi;
	smf_pkg::q62_t         res;
	logic [16:0]           val;

	// one shared 32x32 multiplier, operands by phase; result assembly and compare
	always_comb begin
		op_a = a_q[31:0];
		op_b = b_q[31:0];
		case (phase_q)
			P_M1: op_b = b_q[63:32];
			P_M2: op_a = a_q[63:32];
			P_M3: begin
				op_a = a_q[63:32];
				op_b = b_q[63:32];
			end
			default: ;
		endcase
		mul = {32'd0, op_a} * {32'd0, op_b};
		hi  = p11_q + {32'd0, p01_q[63:32]} + {32'd0, p10_q[63:32]} + {30'd0, mid_q[33:32]};
		res = {hi[61:0], mid_q[31:30]};
		val = xz_q ? 17'h10000 : res[62:46];
		stat.done     = (phase_q == P_FIN);
		stat.accepted = ({1'b0, rnd_q} < val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
		end else begin
			unique case (phase_q)
				P_IDLE:  if (start) phase_q <= P_CLAMP;
				P_CLAMP: phase_q <= P_TAB;
				P_TAB:   phase_q <= P_M0;
				P_M0:    phase_q <= P_M1;
				P_M1:    phase_q <= P_M2;
				P_M2:    phase_q <= P_M3;
				P_M3:    phase_q <= P_MID;
				P_MID:   phase_q <= P_FIN;
				P_FIN:   phase_q <= P_IDLE;
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				prod_q <= {16'd0, dmag} * {{DMW{1'b0}}, inv_temp};
				rnd_q  <= random;
			end
			P_CLAMP: begin
				x_q <= (prod_q > (DMW+16)'(smf_pkg::X_MAX)) ? 12'hFFF : prod_q[11:0];
			end
			P_TAB: begin
				a_q  <= smf_pkg::WHOLE_TAB[x_q[11:8]];
				b_q  <= smf_pkg::FRAC_TAB[x_q[7:0]];
				xz_q <= (x_q == 12'd0);
			end
			P_M0: p00_q <= mul;
			P_M1: p01_q <= mul;
			P_M2: p10_q <= mul;
			P_M3: p11_q <= mul;
			P_MID: begin
				mid_q <= {2'd0, p00_q[63:32]} + {2'd0, p01_q[31:0]} + {2'd0, p10_q[31:0]};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
